// ----- sv/assert_macros.svh -----
// Assertion macros shared by the checker files.
// Needs nothing else; every macro expands to one concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property sampled on the rising clock edge, off while reset is low
`define ORQS_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition in one cycle implies expression in the next
`define ORQS_IMPLY_NEXT(label, clk, rst_n, cond, expr, msg) \
	`ORQS_ASSERT(label, clk, rst_n, (cond) |=> (expr), msg)

`endif

// ----- sv/orqs_pkg.sv -----
// Shared types and constants of the overwriting ring queue with statistics.
// No dependencies; used by the ring, the top level and the checker.
package orqs_pkg;

	localparam int DEPTH_DEF         = 256;
	localparam int PAYLOAD_WIDTH_DEF = 32;
	localparam int CAP_W             = 9;
	localparam int QLEN_W            = 9;

	typedef enum logic [2:0] {
		OP_INSERT  = 3'd0,
		OP_CONSUME = 3'd1,
		OP_SERVICE = 3'd2,
		OP_REPORT  = 3'd3,
		OP_CLEAR   = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		ST_INSERTED  = 3'd0,
		ST_OVERWRITE = 3'd1,
		ST_CONSUMED  = 3'd2,
		ST_EMPTY     = 3'd3,
		ST_STATS     = 3'd4,
		ST_SERVICE   = 3'd5,
		ST_RESET     = 3'd6
	} st_t;

	// ring outcome of the request being accepted
	typedef struct packed {
		logic              lost;
		logic              hit;
		logic [QLEN_W-1:0] qlen;
	} ring_info_t;

endpackage

// ----- sv/orqs_ring.sv -----
// Ring store: entry memories, read/write positions, fill level and capacity.
// Depends on orqs_pkg. Memory read data is registered.
module orqs_ring import orqs_pkg::*; #(
	parameter int DEPTH         = DEPTH_DEF,
	parameter int PAYLOAD_WIDTH = PAYLOAD_WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	input  op_t              op,
	input  logic [31:0]      payload,
	input  logic [31:0]      arrival_time,
	input  logic             cfg_we,
	input  logic [CAP_W-1:0] cfg_data,
	output ring_info_t       info,
	output logic [31:0]      rd_payload,
	output logic [31:0]      rd_time
);

	localparam int PW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int FW      = $clog2(DEPTH + 1);
	localparam int CAP_RST = (DEPTH < 256) ? DEPTH : 256;

	logic [PAYLOAD_WIDTH-1:0] pay_mem [DEPTH];
	logic [31:0]              time_mem [DEPTH];

	logic [PAYLOAD_WIDTH-1:0] rd_pay_s2;
	logic [31:0]              rd_time_s2;

	logic [PW-1:0] rp_q, wp_q, rp_n, wp_n;
	logic [FW-1:0] fill_q, fill_n, cap_q, cap_wr;
	logic [31:0]   cfg32, fill32;
	logic [63:0]   pay_ext, rd_ext;
	logic          lost, hit;

	function automatic logic [PW-1:0] adv(input logic [PW-1:0] p, input logic [FW-1:0] cap);
		logic [FW-1:0] n;
		n = FW'(p) + FW'(1);
		return (n >= cap) ? '0 : n[PW-1:0];
	endfunction

	always_comb begin
		cfg32 = 32'(cfg_data);
		if (cfg32 == 32'd0) begin
			cap_wr = FW'(1);
		end else if (cfg32 > 32'(DEPTH)) begin
			cap_wr = FW'(DEPTH);
		end else begin
			cap_wr = cfg32[FW-1:0];
		end
	end

	always_comb begin
		rp_n   = rp_q;
		wp_n   = wp_q;
		fill_n = fill_q;
		lost   = 1'b0;
		hit    = 1'b0;
		case (op)
			OP_INSERT: begin
				if (fill_q >= cap_q) begin
					rp_n = adv(rp_q, cap_q);
					lost = 1'b1;
				end else begin
					fill_n = fill_q + FW'(1);
				end
				wp_n = adv(wp_q, cap_q);
			end
			OP_CONSUME: begin
				if (fill_q != '0) begin
					rp_n   = adv(rp_q, cap_q);
					fill_n = fill_q - FW'(1);
					hit    = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign fill32     = 32'(fill_n);
	assign info.lost  = lost;
	assign info.hit   = hit;
	assign info.qlen  = fill32[QLEN_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q   <= '0;
			wp_q   <= '0;
			fill_q <= '0;
			cap_q  <= FW'(CAP_RST);
		end else if (cfg_we) begin
			cap_q  <= cap_wr;
			rp_q   <= '0;
			wp_q   <= '0;
			fill_q <= '0;
		end else if (req_valid) begin
			rp_q   <= rp_n;
			wp_q   <= wp_n;
			fill_q <= fill_n;
		end
	end

	assign pay_ext = {32'd0, payload};

	always_ff @(posedge clk) begin
		if (req_valid && op == OP_INSERT) begin
			pay_mem[wp_q]  <= pay_ext[PAYLOAD_WIDTH-1:0];
			time_mem[wp_q] <= arrival_time;
		end
		if (req_valid) begin
			rd_pay_s2  <= pay_mem[rp_q];
			rd_time_s2 <= time_mem[rp_q];
		end
	end

	always_comb begin
		rd_ext                      = '0;
		rd_ext[PAYLOAD_WIDTH-1:0]   = rd_pay_s2;
	end

	assign rd_payload = rd_ext[31:0];
	assign rd_time    = rd_time_s2;

endmodule

// ----- sv/overwriting_ring_queue_stats_top.sv -----
// Top level of the overwriting ring queue with period statistics.
// Depends on orqs_pkg and orqs_ring.
//
// Requests enter on the s_axis group: tuser carries the operation, tdata the
// payload, arrival time, current time and service time. Every request gives
// exactly one result on the m_axis group: tuser the status, tdata the entry
// read (consume only), the queue length and all counters and sums after the
// request. The capacity register is written on the cfg channel; the user must
// do so only while no request is in flight, the block does not enforce it; a
// write empties the queue and keeps the counters.
// A request accepted at a clock edge passes the memory read stage and then
// the result register. The memory read of the oldest entry and the wait-time
// sum sit in the second stage, so one request per cycle is taken in sustained
// flow while the receiver takes the results.
// A stalled receiver holds the result register; the second stage and then
// s_axis_tready follow, so no request is lost or repeated.
//
// Reset empties the queue, clears all counters, sums and the period start
// and sets the capacity to 256 (or DEPTH if smaller). Entries need no clearing.
module overwriting_ring_queue_stats_top import orqs_pkg::*; #(
	parameter int DEPTH         = DEPTH_DEF,
	parameter int PAYLOAD_WIDTH = PAYLOAD_WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	// payload, arrival_time, now, service_time
	input  logic [127:0]     s_axis_tdata,
	// op
	input  logic [2:0]       s_axis_tuser,
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	// out_payload, out_arrival_time, queue_length, received_count, processed_count,
	// lost_count, wait_total, service_total, period_start, zero fill
	output logic [303:0]     m_axis_tdata,
	// status
	output logic [2:0]       m_axis_tuser,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CAP_W-1:0] cfg_data
);

	localparam logic [47:0] SAT48 = '1;

	op_t         op_in, op_s2;
	ring_info_t  info, info_s2;
	logic        acc, adv_s2, valid_s2, m_valid_q;
	logic [31:0] rd_payload, rd_time, now_s2;
	logic [31:0] recv_q, proc_q, lost_q, period_q, recv_n, proc_n, lost_n, period_n;
	logic [47:0] svc_q, svc_n, wait_q, wait_n;
	logic [31:0] recv_s2, proc_s2, lost_s2, period_s2, delta;
	logic [47:0] svc_s2;
	logic [48:0] wait_sum;
	logic [303:0] m_data_q;
	st_t         m_user_q, st_s2;

	function automatic logic [31:0] inc32(input logic [31:0] v);
		return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
	endfunction

	function automatic logic [47:0] add48(input logic [47:0] a, input logic [31:0] v);
		logic [48:0] s;
		s = {1'b0, a} + {17'd0, v};
		return s[48] ? SAT48 : s[47:0];
	endfunction

	assign adv_s2        = !m_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s2 || adv_s2;
	assign acc           = s_axis_tvalid && s_axis_tready;
	assign op_in         = op_t'(s_axis_tuser);
	assign cfg_ready     = 1'b1;

	orqs_ring #(
		.DEPTH         (DEPTH),
		.PAYLOAD_WIDTH (PAYLOAD_WIDTH)
	) u_ring (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (acc),
		.op           (op_in),
		.payload      (s_axis_tdata[31:0]),
		.arrival_time (s_axis_tdata[63:32]),
		.cfg_we       (cfg_valid),
		.cfg_data     (cfg_data),
		.info         (info),
		.rd_payload   (rd_payload),
		.rd_time      (rd_time)
	);

	// first stage: counters that do not need the entry read
	always_comb begin
		recv_n   = recv_q;
		proc_n   = proc_q;
		lost_n   = lost_q;
		svc_n    = svc_q;
		period_n = period_q;
		case (op_in)
			OP_INSERT: begin
				recv_n = inc32(recv_q);
				if (info.lost) begin
					lost_n = inc32(lost_q);
				end
			end
			OP_CONSUME: begin
				if (info.hit) begin
					proc_n = inc32(proc_q);
				end
			end
			OP_SERVICE: svc_n = add48(svc_q, s_axis_tdata[127:96]);
			OP_CLEAR: begin
				recv_n   = '0;
				proc_n   = '0;
				lost_n   = '0;
				svc_n    = '0;
				period_n = s_axis_tdata[95:64];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recv_q   <= '0;
			proc_q   <= '0;
			lost_q   <= '0;
			svc_q    <= '0;
			period_q <= '0;
			valid_s2 <= 1'b0;
		end else begin
			if (acc) begin
				recv_q   <= recv_n;
				proc_q   <= proc_n;
				lost_q   <= lost_n;
				svc_q    <= svc_n;
				period_q <= period_n;
				valid_s2 <= 1'b1;
			end else if (adv_s2) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			op_s2     <= op_in;
			info_s2   <= info;
			now_s2    <= s_axis_tdata[95:64];
			recv_s2   <= recv_n;
			proc_s2   <= proc_n;
			lost_s2   <= lost_n;
			svc_s2    <= svc_n;
			period_s2 <= period_n;
		end
	end

	// second stage: entry data, wait-time sum and status
	assign delta    = now_s2 - rd_time;
	assign wait_sum = {1'b0, wait_q} + {17'd0, delta};

	always_comb begin
		wait_n = wait_q;
		st_s2  = ST_STATS;
		case (op_s2)
			OP_INSERT:  st_s2 = info_s2.lost ? ST_OVERWRITE : ST_INSERTED;
			OP_CONSUME: begin
				if (info_s2.hit) begin
					st_s2  = ST_CONSUMED;
					wait_n = wait_sum[48] ? SAT48 : wait_sum[47:0];
				end else begin
					st_s2 = ST_EMPTY;
				end
			end
			OP_SERVICE: st_s2 = ST_SERVICE;
			OP_CLEAR: begin
				st_s2  = ST_RESET;
				wait_n = '0;
			end
			default: st_s2 = ST_STATS;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wait_q    <= '0;
			m_valid_q <= 1'b0;
		end else if (adv_s2) begin
			m_valid_q <= valid_s2;
			if (valid_s2) begin
				wait_q <= wait_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s2) begin
			m_user_q <= st_s2;
			m_data_q <= {7'd0, period_s2, svc_s2, wait_n, lost_s2, proc_s2, recv_s2,
				info_s2.qlen,
				info_s2.hit ? rd_time : 32'd0,
				info_s2.hit ? rd_payload : 32'd0};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;

endmodule

// ----- sv/orqs_checker.sv -----
// Port-level checks of the ring queue top level, bound to it below.
// Depends on orqs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module orqs_checker import orqs_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             m_axis_tvalid,
	input logic             m_axis_tready,
	input logic [303:0]     m_axis_tdata,
	input logic [2:0]       m_axis_tuser
);

	`ORQS_IMPLY_NEXT(a_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")
	`ORQS_ASSERT(a_empty, clk, arst_n, (m_axis_tvalid && m_axis_tuser == ST_EMPTY) |-> (m_axis_tdata[72:64] == 9'd0), "empty status with entries waiting")
	`ORQS_ASSERT(a_nodata, clk, arst_n, (m_axis_tvalid && m_axis_tuser != ST_CONSUMED) |-> (m_axis_tdata[63:0] == 64'd0), "entry data without consume")
	`ORQS_ASSERT(a_clear, clk, arst_n, (m_axis_tvalid && m_axis_tuser == ST_RESET) |-> (m_axis_tdata[264:73] == '0), "counters not cleared")
	`ORQS_ASSERT(a_fill, clk, arst_n, (m_axis_tvalid && (m_axis_tuser == ST_INSERTED || m_axis_tuser == ST_OVERWRITE)) |-> (m_axis_tdata[72:64] != 9'd0), "insert left queue empty")

endmodule

bind overwriting_ring_queue_stats_top orqs_checker u_orqs_checker (.*);
